### sv/bda_pkg.sv
package bda_pkg;

  localparam int NUM_DIGITS = 5;
  localparam int VALUE_W    = 16;
  localparam int PAD_W      = 8;
  localparam int CHAR_W     = 6;
  localparam int COUNT_W    = 3;
  localparam int DIGIT_W    = 4;
  localparam int IDX_W      = 3;
  localparam int REST_W     = VALUE_W + 1;  // room for 9 x 10000
  localparam int MAX_DIGIT  = 9;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [IDX_W-1:0]  LAST_IDX   = 3'd4;

  localparam int QUEUE_DEPTH = 2;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bda_digits_t;

  // one item in flight through the digit pipeline
  typedef struct packed {
    logic [VALUE_W-1:0]    rest;
    bda_digits_t           digit;
    logic [NUM_DIGITS-1:0] pad_hit;
  } bda_stage_t;

  // one converted item waiting for the emitter
  typedef struct packed {
    bda_digits_t      digit;
    logic [IDX_W-1:0] first;
  } bda_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bda_qstat_t;

  // weight of digit position idx (0 = ten-thousands)
  function automatic int unsigned place_of(input int unsigned idx);
    int unsigned p;
    p = 1;
    unique case (idx)
      0:       p = 10000;
      1:       p = 1000;
      2:       p = 100;
      3:       p = 10;
      default: p = 1;
    endcase
    return p;
  endfunction

  // k times the weight of position idx
  function automatic logic [REST_W-1:0] place_mult(input int unsigned idx,
                                                   input int unsigned k);
    return REST_W'(k * place_of(idx));
  endfunction

endpackage

### sv/bda_if.sv
interface bda_in_if;
  logic                          valid;
  logic                          ready;
  logic [bda_pkg::VALUE_W-1:0]   value;
  logic [bda_pkg::PAD_W-1:0]     pad_width;

  modport source (output valid, value, pad_width, input ready);
  modport sink   (input valid, value, pad_width, output ready);
endinterface

interface bda_out_if;
  logic                          valid;
  logic                          ready;
  logic [bda_pkg::CHAR_W-1:0]    ascii_char;
  logic                          is_last;
  logic [bda_pkg::COUNT_W-1:0]   char_count;

  modport source (output valid, ascii_char, is_last, char_count, input ready);
  modport sink   (input valid, ascii_char, is_last, char_count, output ready);
endinterface

### sv/bda_front.sv
module bda_front (
  input  logic                clk,
  input  logic                rst,
  bda_in_if.sink              bin,
  input  bda_pkg::bda_qstat_t qstat,
  output logic                push,
  output bda_pkg::bda_item_t  push_data
);

  localparam int N = bda_pkg::NUM_DIGITS;

  logic [N-1:0]        vld;
  logic [N-1:0]        take;
  bda_pkg::bda_stage_t stg [N];
  bda_pkg::bda_stage_t src [N];
  bda_pkg::bda_stage_t res [N];

  // a stage takes new data when empty or when its content moves on
  always_comb begin
    take[N-1] = !vld[N-1] || !qstat.full;
    for (int s = N - 2; s >= 0; s--) begin
      take[s] = !vld[s] || take[s+1];
    end
  end

  assign bin.ready = take[0];

  always_comb begin
    src[0].rest  = bin.value;
    src[0].digit = '0;
    for (int i = 0; i < N; i++) begin
      src[0].pad_hit[i] = (bin.pad_width >= bda_pkg::PAD_W'(N - i));
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    if (s > 0) begin : g_link
      assign src[s] = stg[s-1];
    end

    // digit s: parallel compares against the nine multiples of its weight
    always_comb begin
      logic [bda_pkg::DIGIT_W-1:0] d;
      logic [bda_pkg::REST_W-1:0]  sub;
      d   = '0;
      sub = '0;
      for (int k = 1; k <= bda_pkg::MAX_DIGIT; k++) begin
        if ({1'b0, src[s].rest} >= bda_pkg::place_mult(s, k)) begin
          d   = bda_pkg::DIGIT_W'(k);
          sub = bda_pkg::place_mult(s, k);
        end
      end
      res[s]          = src[s];
      res[s].rest     = src[s].rest - sub[bda_pkg::VALUE_W-1:0];
      res[s].digit[s] = d;
    end

    always_ff @(posedge clk) begin
      if (take[s]) begin
        stg[s] <= res[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (take[0]) begin
        vld[0] <= bin.valid;
      end
      for (int s = 1; s < N; s++) begin
        if (take[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  // first printed position: leading nonzero digit, pad limit or units
  always_comb begin
    push_data.digit = stg[N-1].digit;
    push_data.first = bda_pkg::LAST_IDX;
    for (int i = N - 1; i >= 0; i--) begin
      if (stg[N-1].digit[i] != '0 || stg[N-1].pad_hit[i]) begin
        push_data.first = bda_pkg::IDX_W'(i);
      end
    end
  end

  assign push = vld[N-1] && !qstat.full;

endmodule

### sv/bda_queue.sv
module bda_queue #(
  parameter int DEPTH = bda_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bda_pkg::bda_item_t  push_data,
  input  logic                pop,
  output bda_pkg::bda_item_t  pop_data,
  output bda_pkg::bda_qstat_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bda_pkg::bda_item_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   cnt;

  assign stat.full  = (cnt == CNT_W'(DEPTH));
  assign stat.empty = (cnt == '0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

### sv/bda_back.sv
module bda_back (
  input  logic                clk,
  input  logic                rst,
  input  bda_pkg::bda_qstat_t qstat,
  input  bda_pkg::bda_item_t  pop_data,
  output logic                pop,
  bda_out_if.source           chr
);

  logic                         mid;
  logic [bda_pkg::IDX_W-1:0]    cur;
  logic [bda_pkg::IDX_W-1:0]    sel;
  logic [bda_pkg::IDX_W-1:0]    count;
  logic                         out_free;
  logic                         load;

  assign out_free = !chr.valid || chr.ready;
  assign load     = out_free && !qstat.empty;
  assign sel      = mid ? cur : pop_data.first;
  assign count    = sel - pop_data.first + 1'b1;
  assign pop      = load && (sel == bda_pkg::LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      chr.valid <= 1'b0;
      mid       <= 1'b0;
      cur       <= '0;
    end else begin
      if (out_free) begin
        chr.valid <= !qstat.empty;
      end
      if (load) begin
        mid <= (sel != bda_pkg::LAST_IDX);
        cur <= sel + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chr.ascii_char <= bda_pkg::ASCII_ZERO
                      + {{(bda_pkg::CHAR_W - bda_pkg::DIGIT_W){1'b0}},
                         pop_data.digit[sel]};
      chr.is_last    <= (sel == bda_pkg::LAST_IDX);
      chr.char_count <= bda_pkg::COUNT_W'(count);
    end
  end

endmodule

### sv/binary_to_decimal_ascii_core.sv
// Channel | Dir | Payload                              | Meaning
// bin     | in  | value[15:0], pad_width[7:0]          | number and minimum digit count
// chr     | out | ascii_char[5:0], is_last, char_count | one ASCII digit per transfer
//
// Rate: a new item can be taken every cycle unless backed up; it yields 1..5 characters,
//   one per cycle while chr.ready is high; the output register sets the sustained rate.
// Path: the first character is valid after the input passes 5 digit stages, the queue
//   write and the output register.
// Reset: rst clears the stage valid bits, queue pointers and output valid; no sweep.
// Stalls: chr.ready low holds the character; the queue fills, then the digit
//   pipeline, then bin.ready drops.

module binary_to_decimal_ascii_core #(
  parameter int QUEUE_DEPTH = bda_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  bda_in_if.sink    bin,
  bda_out_if.source chr
);

  logic                push;
  logic                pop;
  bda_pkg::bda_item_t  push_data;
  bda_pkg::bda_item_t  pop_data;
  bda_pkg::bda_qstat_t qstat;

  // front: five-stage digit extraction, one decimal place per stage, plus
  // leading-position select on the way into the queue
  bda_front u_front (
    .clk       (clk),
    .rst       (rst),
    .bin       (bin),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  // short queue decouples digit extraction from character emission
  bda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (qstat)
  );

  // back: walks the head item from its first printed digit to the units,
  // popping it on the units character
  bda_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .pop_data (pop_data),
    .pop      (pop),
    .chr      (chr)
  );

  // queue status is never both full and empty
  a_qstat_sane: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty together");

  // nothing to emit and nothing held: output stays idle next cycle
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    qstat.empty && !(chr.valid && !chr.ready) |=> !chr.valid)
    else $error("character emitted with empty queue");

  // every character is a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    chr.valid |-> (chr.ascii_char >= bda_pkg::ASCII_ZERO)
               && (chr.ascii_char <= bda_pkg::ASCII_ZERO + 6'd9))
    else $error("character out of digit range");

  // a non-final character is followed, on its transfer, by more from the same run
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    chr.valid && chr.ready && !chr.is_last |=> chr.valid)
    else $error("run broken before units digit");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Run shape
  localparam int          CLK_HALF     = 10;      // 20 ns period
  localparam int unsigned RANDOM_ITEMS = 480;
  localparam int unsigned LONG_HOLD    = 160;     // chr held off this long while bin keeps offering
  localparam int unsigned DRAIN_CYCLES = 24;      // settle time after the drain, for stray characters
  localparam int unsigned CYCLE_LIMIT  = 400000;  // worst case is far below this

  // One expected character transfer on chr
  typedef struct packed {
    logic [bda_pkg::CHAR_W-1:0]  ascii_char;
    logic                        is_last;
    logic [bda_pkg::COUNT_W-1:0] char_count;
  } dec_char_t;

  // Scoreboard: turns each accepted number into the character string it must
  // produce and matches chr transfers against it in order.
  class digit_scoreboard;
    dec_char_t   char_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function void note_input(logic [bda_pkg::VALUE_W-1:0] value,
                             logic [bda_pkg::PAD_W-1:0] pad_width);
      int unsigned rest;
      int unsigned place;
      int unsigned digit;
      int unsigned pad;
      int unsigned n;
      bit          lead;
      dec_char_t   c;
      rest  = value;
      pad   = (pad_width > bda_pkg::NUM_DIGITS) ? bda_pkg::NUM_DIGITS : pad_width;
      place = 10000;
      n     = 0;
      lead  = 1'b0;
      for (int pos = bda_pkg::NUM_DIGITS; pos >= 1; pos--) begin
        digit = rest / place;
        rest  = rest % place;
        // text starts at first nonzero digit, first padded position, or units
        if (pos <= pad || digit != 0 || pos == 1) lead = 1'b1;
        if (lead) begin
          n++;
          c.ascii_char = bda_pkg::ASCII_ZERO + bda_pkg::CHAR_W'(digit);
          c.is_last    = (pos == 1);
          c.char_count = bda_pkg::COUNT_W'(n);
          char_q.push_back(c);
        end
        place = place / 10;
      end
    endfunction

    function void check_char(logic [bda_pkg::CHAR_W-1:0] ascii_char, logic is_last,
                             logic [bda_pkg::COUNT_W-1:0] char_count);
      dec_char_t want;
      if (char_q.size() == 0) begin
        $error("chr transfer with nothing expected: ascii_char=%0d is_last=%0b char_count=%0d",
               ascii_char, is_last, char_count);
        errors++;
        return;
      end
      want = char_q.pop_front();
      if (ascii_char !== want.ascii_char) begin
        $error("ascii_char: expected %0d, actual %0d", want.ascii_char, ascii_char);
        errors++;
      end
      if (is_last !== want.is_last) begin
        $error("is_last: expected %0b, actual %0b", want.is_last, is_last);
        errors++;
      end
      if (char_count !== want.char_count) begin
        $error("char_count: expected %0d, actual %0d", want.char_count, char_count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return char_q.size();
    endfunction
  endclass

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_STREAM,  // ready every cycle
    RX_COIN,    // ready half the time
    RX_SPARSE,  // ready one cycle in four
    RX_BEAT     // fixed 3-of-7 duty
  } rx_pattern_e;

  logic clk;
  logic rst;

  bda_in_if  bin_if ();
  bda_out_if chr_if ();

  binary_to_decimal_ascii_core uut (
    .clk (clk),
    .rst (rst),
    .bin (bin_if),
    .chr (chr_if)
  );

  digit_scoreboard sb = new();

  // Set by stimulus, taken by the receiver: start a long chr hold-off
  bit long_hold_req = 1'b0;

  // Directed numbers: zero with every pad class, full scale, decade edges,
  // interior zeros, pad at and around the digit count, wide pad, bit patterns
  logic [bda_pkg::VALUE_W-1:0] dir_value [24] = '{
    16'd0, 16'd0, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd1, 16'd9,
    16'd10, 16'd99, 16'd100, 16'd999, 16'd1000, 16'd9999, 16'd10000, 16'd12345,
    16'd7, 16'd7, 16'd7, 16'd7, 16'd42, 16'd50000, 16'h5555, 16'hAAAA
  };
  logic [bda_pkg::PAD_W-1:0] dir_pad [24] = '{
    8'd0, 8'd1, 8'd5, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd3,
    8'd2, 8'd3, 8'd4, 8'd6, 8'd128, 8'd1, 8'hAA, 8'h55
  };

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Offer one number on bin and hold it until the transfer happens. valid
  // stays high on return so a back-to-back item needs no extra edge.
  task automatic send_item(input logic [bda_pkg::VALUE_W-1:0] v,
                           input logic [bda_pkg::PAD_W-1:0] p);
    bin_if.valid     <= 1'b1;
    bin_if.value     <= v;
    bin_if.pad_width <= p;
    do @(posedge clk); while (!bin_if.ready);
    sb.note_input(v, p);
  endtask

  task automatic idle_cycles(input int unsigned n);
    if (n == 0) return;
    bin_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Sender pause until every queued character has come out
  task automatic wait_drained();
    bin_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly numbers of a random digit count so short strings are as common
  // as long ones; some round numbers and some raw 16-bit values. Pad is
  // mostly near the digit range, sometimes any 8-bit value.
  task automatic pick_item(output logic [bda_pkg::VALUE_W-1:0] v,
                           output logic [bda_pkg::PAD_W-1:0] p);
    int unsigned digits;
    int unsigned lo;
    int unsigned hi;
    case ($urandom_range(9))
      0: v = bda_pkg::VALUE_W'($urandom_range(65535));
      1: v = bda_pkg::VALUE_W'($urandom_range(1, 6) * (10 ** $urandom_range(4)));
      default: begin
        digits = $urandom_range(1, bda_pkg::NUM_DIGITS);
        lo     = (digits == 1) ? 0 : 10 ** (digits - 1);
        hi     = (digits == bda_pkg::NUM_DIGITS) ? 65535 : (10 ** digits) - 1;
        v      = bda_pkg::VALUE_W'($urandom_range(hi, lo));
      end
    endcase
    if ($urandom_range(3) == 0) p = bda_pkg::PAD_W'($urandom_range(255));
    else                        p = bda_pkg::PAD_W'($urandom_range(6));
  endtask

  // Receiver: switches pattern at random intervals; a long hold-off
  // request overrides the pattern so the queue and digit stages back up.
  initial begin : receiver
    rx_pattern_e pattern;
    int unsigned left;
    int unsigned hold;
    int unsigned beat;
    pattern = RX_STREAM;
    left    = 0;
    hold    = 0;
    beat    = 0;
    chr_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold          = LONG_HOLD;
      end
      if (left == 0) begin
        pattern = rx_pattern_e'($urandom_range(3));
        left    = $urandom_range(250, 40);
      end
      left--;
      beat++;
      if (hold != 0) begin
        hold--;
        chr_if.ready <= 1'b0;
      end else begin
        case (pattern)
          RX_STREAM: chr_if.ready <= 1'b1;
          RX_COIN:   chr_if.ready <= 1'($urandom_range(1));
          RX_SPARSE: chr_if.ready <= ($urandom_range(3) == 0);
          default:   chr_if.ready <= ((beat % 7) < 3);
        endcase
      end
    end
  end

  // Every chr transfer goes to the scoreboard; sampled at the edge, so the
  // values seen are the ones that were held before it.
  always @(posedge clk) begin
    if (!rst && chr_if.valid && chr_if.ready)
      sb.check_char(chr_if.ascii_char, chr_if.is_last, chr_if.char_count);
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $error("timeout after %0d cycles, %0d characters still expected", CYCLE_LIMIT,
           sb.pending());
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [bda_pkg::VALUE_W-1:0] v;
    logic [bda_pkg::PAD_W-1:0]   p;
    int unsigned                 sent;
    int unsigned                 burst;
    rst              <= 1'b1;
    bin_if.valid     <= 1'b0;
    bin_if.value     <= '0;
    bin_if.pad_width <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, mostly back to back with a short gap now and then
    for (int i = 0; i < 24; i++) begin
      send_item(dir_value[i], dir_pad[i]);
      if (i % 5 == 4) idle_cycles($urandom_range(3, 1));
    end
    wait_drained();

    // Random part: bursts of transfers with random gaps, two long chr
    // hold-offs while bin keeps offering, and one full drain midway
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(24, 1);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        pick_item(v, p);
        send_item(v, p);
        sent++;
        if (sent == 120 || sent == 360) long_hold_req = 1'b1;
        if (sent == 240) wait_drained();
      end
      if ($urandom_range(3) != 0) idle_cycles($urandom_range(8, 1));
    end

    // Let the tail drain, then allow settle time for strays
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected characters never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
